@@ design/hsv_rgb_pkg.sv @@
// Package for the HSV to RGB pixel converter.
// Holds field widths, fixed-point constants, sector codes and stage payload types.
// No dependencies.
`default_nettype none

package hsv_rgb_pkg;

    localparam int HUE_W       = 15;
    localparam int SAT_W       = 16;
    localparam int VAL_W       = 16;
    localparam int FREM_W      = 12;
    localparam int SF_W        = 27;
    localparam int Y_W         = 20;
    localparam int RECIP_W     = 21;

    localparam int HUE_FULL    = 23040;
    localparam int HUE_SECTOR  = 3840;

    localparam int SAT_SHIFT   = 15;
    localparam int DEN_SHIFT   = 23;
    localparam int RECIP_SHIFT = 24;

    localparam logic [SAT_W-1:0]   SAT_ONE  = SAT_W'(32768);
    localparam logic [SF_W-1:0]    FRAC_DEN = SF_W'(32768 * HUE_SECTOR);
    localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(1118482);

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector             sector;
        logic [FREM_W-1:0]   frem;
        logic [SAT_W-1:0]    sat;
        logic [VAL_W-1:0]    val;
        logic                last;
    } t_prep;

    typedef struct packed {
        t_sector             sector;
        logic [VAL_W-1:0]    val;
        logic [VAL_W-1:0]    p;
        logic [VAL_W-1:0]    q;
        logic [VAL_W-1:0]    t;
        logic                last;
    } t_term;

endpackage

`default_nettype wire

@@ design/hsv_rgb_if.sv @@
// Stream interfaces for the HSV to RGB pixel converter: HSV input and RGB output.
// Depends on hsv_rgb_pkg for field widths.
`default_nettype none

interface hsv_rgb_in_if;
    logic                            valid;
    logic                            ready;
    logic [hsv_rgb_pkg::HUE_W-1:0]   hue;
    logic [hsv_rgb_pkg::SAT_W-1:0]   saturation;
    logic [hsv_rgb_pkg::VAL_W-1:0]   brightness;
    logic                            frame_end_in;

    modport source (output valid, hue, saturation, brightness, frame_end_in, input ready);
    modport sink   (input valid, hue, saturation, brightness, frame_end_in, output ready);
endinterface

interface hsv_rgb_out_if;
    logic                            valid;
    logic                            ready;
    logic [hsv_rgb_pkg::VAL_W-1:0]   red;
    logic [hsv_rgb_pkg::VAL_W-1:0]   green;
    logic [hsv_rgb_pkg::VAL_W-1:0]   blue;
    logic                            frame_end_out;

    modport source (output valid, red, green, blue, frame_end_out, input ready);
    modport sink   (input valid, red, green, blue, frame_end_out, output ready);
endinterface

`default_nettype wire

@@ design/hsv_rgb_prep.sv @@
// Input stage: wraps hue, splits it into sector and remainder, clamps saturation.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_prep (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [hsv_rgb_pkg::HUE_W-1:0]   i_hue,
    input  logic [hsv_rgb_pkg::SAT_W-1:0]   i_saturation,
    input  logic [hsv_rgb_pkg::VAL_W-1:0]   i_brightness,
    input  logic                            i_frame_end,
    output logic                            o_valid,
    input  logic                            i_ready,
    output hsv_rgb_pkg::t_prep              o_data
);
    import hsv_rgb_pkg::*;

    t_sector            sec;
    logic [HUE_W-1:0]   base;
    t_prep              n_data;
    t_prep              r_data;
    logic               r_vld;

    always_comb begin
        priority if (i_hue >= HUE_W'(HUE_FULL + 2 * HUE_SECTOR)) begin
            sec  = SEC_2;
            base = HUE_W'(HUE_FULL + 2 * HUE_SECTOR);
        end else if (i_hue >= HUE_W'(HUE_FULL + HUE_SECTOR)) begin
            sec  = SEC_1;
            base = HUE_W'(HUE_FULL + HUE_SECTOR);
        end else if (i_hue >= HUE_W'(HUE_FULL)) begin
            sec  = SEC_0;
            base = HUE_W'(HUE_FULL);
        end else if (i_hue >= HUE_W'(5 * HUE_SECTOR)) begin
            sec  = SEC_5;
            base = HUE_W'(5 * HUE_SECTOR);
        end else if (i_hue >= HUE_W'(4 * HUE_SECTOR)) begin
            sec  = SEC_4;
            base = HUE_W'(4 * HUE_SECTOR);
        end else if (i_hue >= HUE_W'(3 * HUE_SECTOR)) begin
            sec  = SEC_3;
            base = HUE_W'(3 * HUE_SECTOR);
        end else if (i_hue >= HUE_W'(2 * HUE_SECTOR)) begin
            sec  = SEC_2;
            base = HUE_W'(2 * HUE_SECTOR);
        end else if (i_hue >= HUE_W'(HUE_SECTOR)) begin
            sec  = SEC_1;
            base = HUE_W'(HUE_SECTOR);
        end else begin
            sec  = SEC_0;
            base = '0;
        end
    end

    always_comb begin
        n_data.sector = sec;
        n_data.frem   = FREM_W'(i_hue - base);
        n_data.sat    = (i_saturation > SAT_ONE) ? SAT_ONE : i_saturation;
        n_data.val    = i_brightness;
        n_data.last   = i_frame_end;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ design/hsv_rgb_term.sv @@
// Four-stage arithmetic pipeline forming the terms p, q and t with truncation.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_term (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsv_rgb_pkg::t_prep  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsv_rgb_pkg::t_term  o_data
);
    import hsv_rgb_pkg::*;

    typedef struct packed {
        t_sector            sector;
        logic [VAL_W-1:0]   val;
        logic [VAL_W-1:0]   p;
        logic [SF_W-1:0]    sf_q;
        logic [SF_W-1:0]    sf_t;
        logic               last;
    } t_stage_a;

    typedef struct packed {
        t_sector            sector;
        logic [VAL_W-1:0]   val;
        logic [VAL_W-1:0]   p;
        logic [SF_W-1:0]    a_q;
        logic [SF_W-1:0]    a_t;
        logic               last;
    } t_stage_b;

    typedef struct packed {
        t_sector            sector;
        logic [VAL_W-1:0]   val;
        logic [VAL_W-1:0]   p;
        logic [Y_W-1:0]     y_q;
        logic [Y_W-1:0]     y_t;
        logic               last;
    } t_stage_c;

    logic                         rdy_a, rdy_b, rdy_c, rdy_d;
    logic                         r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_stage_a                     r_a, n_a;
    t_stage_b                     r_b, n_b;
    t_stage_c                     r_c, n_c;
    t_term                        r_d, n_d;

    logic [FREM_W-1:0]            frem_t;
    logic [SAT_W-1:0]             inv_s;
    logic [SAT_W+FREM_W-1:0]      prod_sq;
    logic [SAT_W+FREM_W-1:0]      prod_st;
    logic [VAL_W+SAT_W-1:0]       prod_p;
    logic [VAL_W+SF_W-1:0]        prod_vq;
    logic [VAL_W+SF_W-1:0]        prod_vt;
    logic [Y_W+RECIP_W-1:0]       prod_rq;
    logic [Y_W+RECIP_W-1:0]       prod_rt;

    assign rdy_d   = !r_d_vld || i_ready;
    assign rdy_c   = !r_c_vld || rdy_d;
    assign rdy_b   = !r_b_vld || rdy_c;
    assign rdy_a   = !r_a_vld || rdy_b;
    assign o_ready = rdy_a;

    // stage A: saturation products
    always_comb begin
        frem_t  = FREM_W'(HUE_SECTOR) - i_data.frem;
        inv_s   = SAT_ONE - i_data.sat;
        prod_sq = i_data.sat * i_data.frem;
        prod_st = i_data.sat * frem_t;
        prod_p  = i_data.val * inv_s;
        n_a.sector = i_data.sector;
        n_a.val    = i_data.val;
        n_a.p      = prod_p[SAT_SHIFT+VAL_W-1:SAT_SHIFT];
        n_a.sf_q   = prod_sq[SF_W-1:0];
        n_a.sf_t   = prod_st[SF_W-1:0];
        n_a.last   = i_data.last;
    end

    // stage B: complement against the full-scale denominator
    always_comb begin
        n_b.sector = r_a.sector;
        n_b.val    = r_a.val;
        n_b.p      = r_a.p;
        n_b.a_q    = FRAC_DEN - r_a.sf_q;
        n_b.a_t    = FRAC_DEN - r_a.sf_t;
        n_b.last   = r_a.last;
    end

    // stage C: scale by value, drop the power-of-two part of the denominator
    always_comb begin
        prod_vq    = r_b.val * r_b.a_q;
        prod_vt    = r_b.val * r_b.a_t;
        n_c.sector = r_b.sector;
        n_c.val    = r_b.val;
        n_c.p      = r_b.p;
        n_c.y_q    = prod_vq[DEN_SHIFT+Y_W-1:DEN_SHIFT];
        n_c.y_t    = prod_vt[DEN_SHIFT+Y_W-1:DEN_SHIFT];
        n_c.last   = r_b.last;
    end

    // stage D: divide by 15 through the reciprocal
    always_comb begin
        prod_rq    = r_c.y_q * RECIP_15;
        prod_rt    = r_c.y_t * RECIP_15;
        n_d.sector = r_c.sector;
        n_d.val    = r_c.val;
        n_d.p      = r_c.p;
        n_d.q      = prod_rq[RECIP_SHIFT+VAL_W-1:RECIP_SHIFT];
        n_d.t      = prod_rt[RECIP_SHIFT+VAL_W-1:RECIP_SHIFT];
        n_d.last   = r_c.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_vld <= i_valid;
            end
            if (rdy_b) begin
                r_b_vld <= r_a_vld;
            end
            if (rdy_c) begin
                r_c_vld <= r_b_vld;
            end
            if (rdy_d) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (rdy_b && r_a_vld) begin
            r_b <= n_b;
        end
        if (rdy_c && r_b_vld) begin
            r_c <= n_c;
        end
        if (rdy_d && r_c_vld) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_d_vld;
    assign o_data  = r_d;

endmodule

`default_nettype wire

@@ design/hsv_rgb_route.sv @@
// Output stage: routes v, p, q and t to red, green and blue by sector.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_route (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  hsv_rgb_pkg::t_term              i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [hsv_rgb_pkg::VAL_W-1:0]   o_red,
    output logic [hsv_rgb_pkg::VAL_W-1:0]   o_green,
    output logic [hsv_rgb_pkg::VAL_W-1:0]   o_blue,
    output logic                            o_frame_end
);
    import hsv_rgb_pkg::*;

    logic               r_vld;
    logic [VAL_W-1:0]   r_red, r_green, r_blue;
    logic               r_last;
    logic [VAL_W-1:0]   n_red, n_green, n_blue;

    always_comb begin
        unique case (i_data.sector)
            SEC_0: begin
                n_red = i_data.val; n_green = i_data.t;   n_blue = i_data.p;
            end
            SEC_1: begin
                n_red = i_data.q;   n_green = i_data.val; n_blue = i_data.p;
            end
            SEC_2: begin
                n_red = i_data.p;   n_green = i_data.val; n_blue = i_data.t;
            end
            SEC_3: begin
                n_red = i_data.p;   n_green = i_data.q;   n_blue = i_data.val;
            end
            SEC_4: begin
                n_red = i_data.t;   n_green = i_data.p;   n_blue = i_data.val;
            end
            SEC_5: begin
                n_red = i_data.val; n_green = i_data.p;   n_blue = i_data.q;
            end
            default: begin
                n_red = i_data.val; n_green = i_data.val; n_blue = i_data.val;
            end
        endcase
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_last  <= i_data.last;
        end
    end

    assign o_valid     = r_vld;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_frame_end = r_last;

endmodule

`default_nettype wire

@@ design/hsv_to_rgb_pixel_unit.sv @@
// HSV to RGB pixel converter, hexcone rule, top level.
// Throughput: one pixel per cycle when the output is not stalled, set by the six-register pipeline
// (prep, four arithmetic stages, route), each stage with its own valid bit.
// Reset (synchronous, active low) clears all valid bits; the data registers are not reset.
// Depends on hsv_rgb_pkg, hsv_rgb_if, hsv_rgb_prep, hsv_rgb_term, hsv_rgb_route.
`default_nettype none

module hsv_to_rgb_pixel_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hsv_rgb_in_if.sink      i_pix,
    hsv_rgb_out_if.source   o_pix
);
    import hsv_rgb_pkg::*;

    logic   prep_vld, prep_rdy;
    t_prep  prep_data;
    logic   term_vld, term_rdy;
    t_term  term_data;

    hsv_rgb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_pix.valid),
        .o_ready      (i_pix.ready),
        .i_hue        (i_pix.hue),
        .i_saturation (i_pix.saturation),
        .i_brightness (i_pix.brightness),
        .i_frame_end  (i_pix.frame_end_in),
        .o_valid      (prep_vld),
        .i_ready      (prep_rdy),
        .o_data       (prep_data)
    );

    hsv_rgb_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_vld),
        .o_ready (prep_rdy),
        .i_data  (prep_data),
        .o_valid (term_vld),
        .i_ready (term_rdy),
        .o_data  (term_data)
    );

    hsv_rgb_route u_route (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (term_vld),
        .o_ready     (term_rdy),
        .i_data      (term_data),
        .o_valid     (o_pix.valid),
        .i_ready     (o_pix.ready),
        .o_red       (o_pix.red),
        .o_green     (o_pix.green),
        .o_blue      (o_pix.blue),
        .o_frame_end (o_pix.frame_end_out)
    );

endmodule

`default_nettype wire

@@ design/hsv_rgb_check.sv @@
// Port-level assertions for hsv_to_rgb_pixel_unit and the bind that attaches them.
// Depends on hsv_rgb_pkg for field widths.
`default_nettype none

module hsv_rgb_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [hsv_rgb_pkg::SAT_W-1:0]   i_saturation,
    input  logic [hsv_rgb_pkg::VAL_W-1:0]   i_brightness,
    input  logic                            i_frame_end_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [hsv_rgb_pkg::VAL_W-1:0]   i_red,
    input  logic [hsv_rgb_pkg::VAL_W-1:0]   i_green,
    input  logic [hsv_rgb_pkg::VAL_W-1:0]   i_blue,
    input  logic                            i_frame_end_out
);
    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue) && $stable(i_frame_end_out))
        else $error("stalled output transfer changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty output stage");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready |=> i_out_valid
            && i_frame_end_out == $past(i_frame_end_in, 6))
        else $error("pixel not delivered after pipeline latency");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_saturation == '0 ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready |=> i_red == $past(i_brightness, 6)
            && i_green == i_red && i_blue == i_red)
        else $error("zero saturation did not give gray");

endmodule

bind hsv_to_rgb_pixel_unit hsv_rgb_check u_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_saturation    (i_pix.saturation),
    .i_brightness    (i_pix.brightness),
    .i_frame_end_in  (i_pix.frame_end_in),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_red           (o_pix.red),
    .i_green         (o_pix.green),
    .i_blue          (o_pix.blue),
    .i_frame_end_out (o_pix.frame_end_out)
);

`default_nettype wire

@@ verif/tb_hsv_to_rgb_pixel_unit.sv @@
// Testbench for hsv_to_rgb_pixel_unit: directed and random HSV pixels against a hexcone predictor.
// Random valid and ready gaps on both streams, field-by-field checks of every RGB transfer.
// Depends on hsv_rgb_pkg, hsv_rgb_if and the design under test.
module tb_hsv_to_rgb_pixel_unit;
    import hsv_rgb_pkg::*;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
        logic             last;
    } t_hsv_pixel;

    typedef struct {
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
        logic             last;
    } t_rgb_pixel;

    localparam int RANDOM_PIXELS = 1000;
    localparam int IDLE_PCT      = 31;
    localparam int CALM_FROM     = 400;
    localparam int CALM_TO       = 600;
    localparam int PIPE_DEPTH    = 6;

    logic i_clk;
    logic i_rst_n;

    hsv_rgb_in_if  hsv_in ();
    hsv_rgb_out_if rgb_out ();

    hsv_to_rgb_pixel_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (hsv_in),
        .o_pix   (rgb_out)
    );

    t_hsv_pixel  hsv_pending[$];
    t_rgb_pixel  rgb_expected[$];
    logic        hsv_took;
    int unsigned taken_count;
    int unsigned given_count;
    int unsigned mismatch_count;

    function automatic t_rgb_pixel predict_rgb(t_hsv_pixel pix);
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned frem;
        longint unsigned den;
        longint unsigned term_p;
        longint unsigned term_q;
        longint unsigned term_t;
        t_sector         sec;
        t_rgb_pixel      rgb;
        h   = 64'(pix.hue);
        s   = 64'(pix.sat);
        v   = 64'(pix.val);
        den = longint'(SAT_ONE) * HUE_SECTOR;
        if (s > SAT_ONE) begin
            s = SAT_ONE;
        end
        if (h >= HUE_FULL) begin
            h = h - HUE_FULL;
        end
        rgb.last = pix.last;
        if (s == 0) begin
            rgb.red   = pix.val;
            rgb.green = pix.val;
            rgb.blue  = pix.val;
            return rgb;
        end
        sec    = t_sector'(h / HUE_SECTOR);
        frem   = h % HUE_SECTOR;
        term_p = (v * (SAT_ONE - s)) >> SAT_SHIFT;
        term_q = (v * (den - s * frem)) / den;
        term_t = (v * (den - s * (HUE_SECTOR - frem))) / den;
        case (sec)
            SEC_0: begin
                rgb.red = VAL_W'(v); rgb.green = VAL_W'(term_t); rgb.blue = VAL_W'(term_p);
            end
            SEC_1: begin
                rgb.red = VAL_W'(term_q); rgb.green = VAL_W'(v); rgb.blue = VAL_W'(term_p);
            end
            SEC_2: begin
                rgb.red = VAL_W'(term_p); rgb.green = VAL_W'(v); rgb.blue = VAL_W'(term_t);
            end
            SEC_3: begin
                rgb.red = VAL_W'(term_p); rgb.green = VAL_W'(term_q); rgb.blue = VAL_W'(v);
            end
            SEC_4: begin
                rgb.red = VAL_W'(term_t); rgb.green = VAL_W'(term_p); rgb.blue = VAL_W'(v);
            end
            default: begin
                rgb.red = VAL_W'(v); rgb.green = VAL_W'(term_p); rgb.blue = VAL_W'(term_q);
            end
        endcase
        return rgb;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("mismatch at result %0d, %s: expected %0d, got %0d",
                     given_count, what, want, got);
        end
    endtask

    task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v, bit l);
        t_hsv_pixel pix;
        pix.hue  = HUE_W'(h);
        pix.sat  = SAT_W'(s);
        pix.val  = VAL_W'(v);
        pix.last = l;
        hsv_pending.push_back(pix);
    endtask

    task automatic add_random_pixel();
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            h = $urandom_range(0, HUE_FULL - 1);
        end else if (pick < 85) begin
            h = $urandom_range(0, 5) * HUE_SECTOR + $urandom_range(0, 2) * 1919;
            h = (h % HUE_SECTOR == 3838) ? h + 1 : h;
        end else begin
            h = $urandom_range(HUE_FULL, 32767);
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            s = 0;
        end else if (pick < 20) begin
            s = SAT_ONE;
        end else if (pick < 30) begin
            s = $urandom_range(SAT_ONE + 1, 65535);
        end else begin
            s = $urandom_range(1, SAT_ONE - 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            v = 0;
        end else if (pick < 10) begin
            v = 65535;
        end else begin
            v = $urandom_range(0, 65535);
        end
        add_pixel(h, s, v, $urandom_range(0, 15) == 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 200_000);
        $display("FAILURE");
        $finish;
    end

    // input side: record transfers and predict
    always @(posedge i_clk) begin
        t_hsv_pixel pix;
        hsv_took <= i_rst_n && hsv_in.valid && hsv_in.ready;
        if (i_rst_n && hsv_in.valid && hsv_in.ready) begin
            pix.hue  = hsv_in.hue;
            pix.sat  = hsv_in.saturation;
            pix.val  = hsv_in.brightness;
            pix.last = hsv_in.frame_end_in;
            rgb_expected.push_back(predict_rgb(pix));
            taken_count++;
        end
    end

    // driver: advance on transfer, idle at random outside the calm stretch
    always @(negedge i_clk) begin
        t_hsv_pixel pix;
        if (i_rst_n && (!hsv_in.valid || hsv_took)) begin
            if (hsv_pending.size() != 0 &&
                ((taken_count >= CALM_FROM && taken_count < CALM_TO) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                pix = hsv_pending.pop_front();
                hsv_in.hue          <= pix.hue;
                hsv_in.saturation   <= pix.sat;
                hsv_in.brightness   <= pix.val;
                hsv_in.frame_end_in <= pix.last;
                hsv_in.valid        <= 1'b1;
            end else begin
                hsv_in.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        rgb_out.ready <= i_rst_n &&
            ((given_count >= CALM_FROM && given_count < CALM_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && rgb_out.valid && rgb_out.ready) begin
            if (rgb_expected.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = rgb_expected.pop_front();
                if (rgb_out.red !== want.red) begin
                    report_mismatch("red", 32'(want.red), 32'(rgb_out.red));
                end
                if (rgb_out.green !== want.green) begin
                    report_mismatch("green", 32'(want.green), 32'(rgb_out.green));
                end
                if (rgb_out.blue !== want.blue) begin
                    report_mismatch("blue", 32'(want.blue), 32'(rgb_out.blue));
                end
                if (rgb_out.frame_end_out !== want.last) begin
                    report_mismatch("frame_end_out", 32'(want.last),
                                    32'(rgb_out.frame_end_out));
                end
            end
            given_count++;
        end
    end

    initial begin
        int drain;
        i_rst_n                = 1'b0;
        hsv_in.valid           = 1'b0;
        hsv_in.hue             = '0;
        hsv_in.saturation      = '0;
        hsv_in.brightness      = '0;
        hsv_in.frame_end_in    = 1'b0;
        rgb_out.ready          = 1'b0;
        hsv_took               = 1'b0;
        taken_count            = 0;
        given_count            = 0;
        mismatch_count         = 0;

        for (int sec = 0; sec < 6; sec++) begin
            add_pixel(sec * HUE_SECTOR + 1920, 20000, 50000, 1'b0);
        end
        add_pixel(0, SAT_ONE, 65535, 1'b0);
        add_pixel(HUE_SECTOR - 1, SAT_ONE, 65535, 1'b0);
        add_pixel(HUE_SECTOR, 32767, 65535, 1'b0);
        add_pixel(HUE_FULL - 1, SAT_ONE, 65535, 1'b1);
        add_pixel(HUE_FULL, 30000, 40000, 1'b0);
        add_pixel(32767, 30000, 40000, 1'b0);
        add_pixel(HUE_FULL + 1, 1, 65535, 1'b0);
        add_pixel(5000, 0, 12345, 1'b0);
        add_pixel(5000, 0, 65535, 1'b1);
        add_pixel(9000, 32769, 65535, 1'b0);
        add_pixel(13000, 65535, 54321, 1'b0);
        add_pixel(17000, SAT_ONE, 0, 1'b0);
        add_pixel(21000, 1, 1, 1'b0);
        add_pixel(2 * HUE_SECTOR + 1, 32767, 65535, 1'b1);
        add_pixel(5 * HUE_SECTOR - 1, 16384, 32768, 1'b0);
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            add_random_pixel();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold until all transfers are in and every prediction is matched
        drain = 0;
        while ((hsv_pending.size() != 0 || hsv_in.valid || rgb_expected.size() != 0) &&
               drain < 100_000) begin
            @(posedge i_clk);
            if (hsv_pending.size() == 0 && !hsv_in.valid) begin
                drain++;
            end
        end
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (rgb_expected.size() != 0) begin
            report_mismatch("results never delivered", rgb_expected.size(), 0);
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/hsv_rgb_pkg.sv
design/hsv_rgb_if.sv
design/hsv_rgb_prep.sv
design/hsv_rgb_term.sv
design/hsv_rgb_route.sv
design/hsv_to_rgb_pixel_unit.sv
design/hsv_rgb_check.sv
verif/tb_hsv_to_rgb_pixel_unit.sv
